// ===== rtl/core/tkf_pkg.sv =====
// ---------------------------------------------------------------------------
// tkf_pkg: shared constants and helpers for the tilt Kalman fusion block
// Fixed-point constants, register indexes, atan table, saturation helpers.
// ---------------------------------------------------------------------------
`default_nettype none
package tkf_pkg;

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_STEP_PERIOD  = 3'd0,
    REG_PNOISE_ROLL  = 3'd1,
    REG_PNOISE_PITCH = 3'd2,
    REG_MNOISE_ROLL  = 3'd3,
    REG_MNOISE_PITCH = 3'd4,
    REG_GATE_LIMIT   = 3'd5,
    REG_INIT_VAR     = 3'd6
  } reg_index_t;

  // sensor bias removal, Q4.12 and Q24
  localparam logic signed [16:0] BIAS_AX = 17'sd445;
  localparam logic signed [16:0] BIAS_AY = 17'sd21;
  localparam logic signed [16:0] BIAS_AZ = 17'sd694;
  localparam logic signed [29:0] GYRO_BIAS_ROLL  = 30'sd120897;
  localparam logic signed [29:0] GYRO_BIAS_PITCH = 30'sd58485;

  // deg/s Q6 -> rad/s, and rad -> command scale (10/pi) in Q24
  localparam logic signed [26:0] DEG_TO_RAD_Q30 = 27'sd18740330;
  localparam logic signed [26:0] CMD_SCALE_Q24  = 27'sd53403537;
  localparam logic [24:0]        ONE_Q24        = 25'h1000000;

  // register reset values
  localparam logic [15:0] RST_STEP_PERIOD = 16'd655;
  localparam logic [23:0] RST_PNOISE      = 24'd262144;
  localparam logic [23:0] RST_MNOISE_ROLL = 24'd119;
  localparam logic [23:0] RST_MNOISE_PITCH = 24'd419;
  localparam logic [14:0] RST_GATE_LIMIT  = 15'd10650;
  localparam logic [31:0] RST_INIT_VAR    = 32'd262144;

  // CORDIC angle table, rad Q30
  function automatic logic signed [31:0] atan_q30(input logic [4:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0:  r = 32'sd843314857;
      5'd1:  r = 32'sd497837829;
      5'd2:  r = 32'sd263043837;
      5'd3:  r = 32'sd133525159;
      5'd4:  r = 32'sd67021687;
      5'd5:  r = 32'sd33543516;
      5'd6:  r = 32'sd16775851;
      5'd7:  r = 32'sd8388437;
      5'd8:  r = 32'sd4194283;
      5'd9:  r = 32'sd2097149;
      5'd10: r = 32'sd1048576;
      5'd11: r = 32'sd524288;
      5'd12: r = 32'sd262144;
      5'd13: r = 32'sd131072;
      5'd14: r = 32'sd65536;
      5'd15: r = 32'sd32768;
      5'd16: r = 32'sd16384;
      5'd17: r = 32'sd8192;
      5'd18: r = 32'sd4096;
      5'd19: r = 32'sd2048;
      5'd20: r = 32'sd1024;
      5'd21: r = 32'sd512;
      5'd22: r = 32'sd256;
      5'd23: r = 32'sd128;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  // clamp to 16 bit signed
  function automatic logic signed [15:0] sat16(input logic signed [39:0] v);
    logic signed [15:0] r;
    if (v > 40'sd32767) r = 16'sh7fff;
    else if (v < -40'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  // clamp to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh07fffffff) r = 32'sh7fffffff;
    else if (v < -36'sh080000000) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tkf_mul.sv =====
// ---------------------------------------------------------------------------
// tkf_mul: shared signed multiplier
// 36 x 27 signed product, registered; the result follows in the cycle after the operands.
// ---------------------------------------------------------------------------
`default_nettype none
module tkf_mul (
  input  wire                      clk,
  input  wire  logic signed [35:0] a,
  input  wire  logic signed [26:0] b,
  output logic signed [62:0]       p
);

  // product register, operands sign-extended to the full product width
  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tkf_isqrt.sv =====
// ---------------------------------------------------------------------------
// tkf_isqrt: iterative integer square root
// Floor square root of a 62-bit value, one result bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module tkf_isqrt (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  logic [61:0] value,
  output logic              done,
  output logic [30:0]       root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [61:0] data;
  logic [34:0] rem;
  logic [34:0] rem_sh;
  logic [34:0] trial;

  // next partial remainder and trial subtrahend
  always_comb begin
    rem_sh = {rem[32:0], data[61:60]};
    trial  = {2'b00, root, 2'b01};
  end

  // digit recurrence
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      data <= value;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      data <= {data[59:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[29:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[29:0], 1'b0};
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'd30) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tkf_cordic.sv =====
// ---------------------------------------------------------------------------
// tkf_cordic: iterative CORDIC vectoring unit
// atan2(y, x) for x >= 0 in rad Q30, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module tkf_cordic #(
  parameter int STEPS = 16
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire  logic signed [32:0] x_in,
  input  wire  logic signed [32:0] y_in,
  output logic                     done,
  output logic signed [31:0]       z
);

  logic               busy;
  logic [4:0]         cnt;
  logic signed [34:0] x;
  logic signed [34:0] y;
  logic signed [34:0] xs;
  logic signed [34:0] ys;

  // shifted copies for this step
  always_comb begin
    xs = x >>> cnt;
    ys = y >>> cnt;
  end

  // rotation sequencer
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      x   <= 35'(x_in);
      y   <= 35'(y_in);
      z   <= '0;
      cnt <= '0;
      // zero vector gives angle zero at once
      if (x_in == '0 && y_in == '0) begin
        done <= 1'b1;
      end else begin
        busy <= 1'b1;
      end
    end else if (busy) begin
      if (!y[34]) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + tkf_pkg::atan_q30(cnt);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - tkf_pkg::atan_q30(cnt);
      end
      cnt <= cnt + 5'd1;
      if (cnt == 5'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tkf_div.sv =====
// ---------------------------------------------------------------------------
// tkf_div: iterative gain divider
// floor(2^24 * num / den) for num <= den, restoring, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none
module tkf_div (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire  logic [31:0] num,
  input  wire  logic [32:0] den,
  output logic              done,
  output logic [24:0]       quo
);

  logic        busy;
  logic        den_zero;
  logic [4:0]  cnt;
  logic [33:0] rem;
  logic [32:0] dv;
  logic        bit_q;
  logic [33:0] rem_sub;

  // trial subtract
  always_comb begin
    bit_q   = (rem >= {1'b0, dv});
    rem_sub = bit_q ? (rem - {1'b0, dv}) : rem;
  end

  // quotient bits from the top
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      cnt      <= '0;
      rem      <= {2'b00, num};
      dv       <= den;
      den_zero <= (den == '0);
      quo      <= '0;
    end else if (busy) begin
      rem <= {rem_sub[32:0], 1'b0};
      quo <= {quo[23:0], bit_q};
      cnt <= cnt + 5'd1;
      if (cnt == 5'd24) begin
        busy <= 1'b0;
        done <= 1'b1;
        // zero denominator gives zero gain
        if (den_zero) quo <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tilt_kalman_fusion_unit.sv =====
// ---------------------------------------------------------------------------
// tilt_kalman_fusion_unit: accelerometer/gyro tilt estimator
// Accel tilt by isqrt + CORDIC, fused with gyro rate by two scalar Kalman
// filters run one after the other on one shared multiplier and divider.
// ---------------------------------------------------------------------------
// Sequence: per axis a square root, a CORDIC pass (finished at once for a
//   zero vector), a gain divide and the multiply steps, then the command
//   steps and the output register.
// A new item is taken only once the last one is done: s_tready is high
//   only while idle, and a result held by m_tready stalls the output step.
// Reset: clears estimates, loads both variances with the initial variance,
//   restores the configuration registers to their defaults and drops m_tvalid.
`default_nettype none
module tilt_kalman_fusion_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               s_tvalid,
  output logic              s_tready,
  // accel_x, accel_y, accel_z, gyro_roll_rate, gyro_pitch_rate
  input  wire  logic [79:0] s_tdata,
  output logic              m_tvalid,
  input  wire               m_tready,
  // roll_angle, pitch_angle, accel_roll_angle, forward_cmd, turn_cmd
  output logic [79:0]       m_tdata,
  input  wire               cfg_valid,
  output logic              cfg_ready,
  input  wire  logic [2:0]  cfg_index,
  input  wire  logic [23:0] cfg_data
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SQA, ST_SQB, ST_SQS, ST_ROOT, ST_ATAN, ST_RATE, ST_DT2,
    ST_DTR, ST_NOISE, ST_FP, ST_DIVS, ST_DIV, ST_UPD, ST_VAR, ST_VST,
    ST_CMD1, ST_CMD2, ST_CMD3, ST_OUT
  } state_t;

  state_t state;
  logic   axis;

  // configuration
  logic [15:0] step_period;
  logic [23:0] pnoise_roll;
  logic [23:0] pnoise_pitch;
  logic [23:0] mnoise_roll;
  logic [23:0] mnoise_pitch;
  logic [14:0] gate_limit;

  // item and working registers
  logic signed [16:0] ax, ay, az;
  logic signed [15:0] gr, gp;
  logic [31:0]        sacc;
  logic signed [31:0] ang;
  logic signed [15:0] acc13;
  logic               gate;
  logic signed [29:0] rate;
  logic [31:0]        dtdt;
  logic signed [35:0] f;
  logic [31:0]        fp;
  logic [24:0]        k;
  logic signed [15:0] fwd, turn;

  // filter state
  logic signed [31:0] est_roll, est_pitch;
  logic [31:0]        var_roll, var_pitch;

  // output register
  logic [79:0] out_data;

  // shared units
  logic signed [35:0] mul_a;
  logic signed [26:0] mul_b;
  logic signed [62:0] mul_p;
  logic               sq_start, sq_done;
  logic [30:0]        sq_root;
  logic               cd_start, cd_done;
  logic signed [31:0] cd_z;
  logic               dv_start, dv_done;
  logic [24:0]        dv_q;

  // per-axis selections
  logic signed [16:0] sel_a, sel_b, sel_num;
  logic signed [31:0] est_sel;
  logic [31:0]        var_sel;
  logic [23:0]        q_sel, r_sel;
  logic signed [25:0] meas;
  logic [32:0]        den;

  // combinational results of the current multiply and of the CORDIC angle
  logic signed [62:0] t_rate, t_f, t_upd, t_fwd, t_turn;
  logic [32:0]        fp_sum;
  logic signed [15:0] acc13_n;
  logic [15:0]        acc13_abs;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tdata   = out_data;

  // axis operand selection
  always_comb begin
    sel_a   = axis ? ay : ax;
    sel_b   = az;
    sel_num = axis ? -ax : ay;
    est_sel = axis ? est_pitch : est_roll;
    var_sel = axis ? var_pitch : var_roll;
    q_sel   = axis ? pnoise_pitch : pnoise_roll;
    r_sel   = axis ? mnoise_pitch : mnoise_roll;
    meas    = 26'((ang + 32'sd32) >>> 6);
    den     = {1'b0, fp} + {9'd0, r_sel};
  end

  // multiplier operand mux
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQA:   begin mul_a = 36'(sel_a); mul_b = 27'(sel_a); end
      ST_SQB:   begin mul_a = 36'(sel_b); mul_b = 27'(sel_b); end
      ST_RATE:  begin mul_a = 36'(axis ? gp : gr); mul_b = tkf_pkg::DEG_TO_RAD_Q30; end
      ST_DT2:   begin
        mul_a = $signed({20'd0, step_period});
        mul_b = $signed({11'd0, step_period});
      end
      ST_DTR:   begin mul_a = 36'(rate); mul_b = $signed({11'd0, step_period}); end
      ST_NOISE: begin mul_a = $signed({4'd0, dtdt}); mul_b = $signed({3'd0, q_sel}); end
      ST_UPD:   begin mul_a = 36'(meas) - f; mul_b = $signed({2'b00, k}); end
      ST_VAR:   begin
        mul_a = $signed({4'd0, fp});
        mul_b = $signed({2'b00, tkf_pkg::ONE_Q24 - k});
      end
      ST_CMD1:  begin mul_a = 36'(est_pitch); mul_b = tkf_pkg::CMD_SCALE_Q24; end
      ST_CMD2:  begin mul_a = 36'(est_roll); mul_b = tkf_pkg::CMD_SCALE_Q24; end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // rounding of multiplier results and of the CORDIC angle
  always_comb begin
    t_rate    = (mul_p + 63'sd2048) >>> 12;
    t_f       = (mul_p + 63'sd32768) >>> 16;
    t_upd     = (mul_p + 63'sd8388608) >>> 24;
    t_fwd     = (mul_p + 63'sh800000000) >>> 36;
    t_turn    = (63'sh800000000 - mul_p) >>> 36;
    fp_sum    = {1'b0, var_sel} + {2'b00, mul_p[62:32] + {30'd0, mul_p[31]}};
    acc13_n   = 16'((cd_z + 32'sd65536) >>> 17);
    acc13_abs = acc13_n[15] ? 16'(-acc13_n) : acc13_n;
  end

  assign sq_start = (state == ST_SQS);
  assign cd_start = (state == ST_ROOT) && sq_done;
  assign dv_start = (state == ST_DIVS);

  tkf_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  tkf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value ({sacc + mul_p[31:0], 30'd0}),
    .done  (sq_done),
    .root  (sq_root)
  );

  tkf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cd_start),
    .x_in  ($signed({2'b00, sq_root})),
    .y_in  ($signed({sel_num[16], sel_num, 15'd0})),
    .done  (cd_done),
    .z     (cd_z)
  );

  tkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (dv_start),
    .num   (fp),
    .den   (den),
    .done  (dv_done),
    .quo   (dv_q)
  );

  // configuration registers; initial variance is only applied by reset,
  // which also restores its default, so its writes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      step_period  <= tkf_pkg::RST_STEP_PERIOD;
      pnoise_roll  <= tkf_pkg::RST_PNOISE;
      pnoise_pitch <= tkf_pkg::RST_PNOISE;
      mnoise_roll  <= tkf_pkg::RST_MNOISE_ROLL;
      mnoise_pitch <= tkf_pkg::RST_MNOISE_PITCH;
      gate_limit   <= tkf_pkg::RST_GATE_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        tkf_pkg::REG_STEP_PERIOD:  step_period  <= cfg_data[15:0];
        tkf_pkg::REG_PNOISE_ROLL:  pnoise_roll  <= cfg_data;
        tkf_pkg::REG_PNOISE_PITCH: pnoise_pitch <= cfg_data;
        tkf_pkg::REG_MNOISE_ROLL:  mnoise_roll  <= cfg_data;
        tkf_pkg::REG_MNOISE_PITCH: mnoise_pitch <= cfg_data;
        tkf_pkg::REG_GATE_LIMIT:   gate_limit   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      axis      <= 1'b0;
      m_tvalid  <= 1'b0;
      est_roll  <= '0;
      est_pitch <= '0;
      var_roll  <= tkf_pkg::RST_INIT_VAR;
      var_pitch <= tkf_pkg::RST_INIT_VAR;
    end else begin
      // the output step sets m_tvalid itself
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            ax    <= $signed({s_tdata[15], s_tdata[15:0]}) - tkf_pkg::BIAS_AX;
            ay    <= $signed({s_tdata[31], s_tdata[31:16]}) + tkf_pkg::BIAS_AY;
            az    <= $signed({s_tdata[47], s_tdata[47:32]}) - tkf_pkg::BIAS_AZ;
            gr    <= s_tdata[63:48];
            gp    <= s_tdata[79:64];
            axis  <= 1'b0;
            state <= ST_SQA;
          end
        end
        ST_SQA: state <= ST_SQB;
        ST_SQB: begin
          sacc  <= mul_p[31:0];
          state <= ST_SQS;
        end
        ST_SQS: state <= ST_ROOT;
        ST_ROOT: if (sq_done) state <= ST_ATAN;
        ST_ATAN: begin
          if (cd_done) begin
            ang <= cd_z;
            if (!axis) begin
              acc13 <= acc13_n;
              gate  <= (acc13_abs > {1'b0, gate_limit});
            end
            state <= ST_RATE;
          end
        end
        ST_RATE: state <= ST_DT2;
        ST_DT2: begin
          rate  <= 30'(t_rate) + (axis ? tkf_pkg::GYRO_BIAS_PITCH
                                       : tkf_pkg::GYRO_BIAS_ROLL);
          state <= ST_DTR;
        end
        ST_DTR: begin
          dtdt  <= mul_p[31:0];
          state <= ST_NOISE;
        end
        ST_NOISE: begin
          f     <= 36'(est_sel) + 36'(t_f);
          state <= ST_FP;
        end
        ST_FP: begin
          fp    <= fp_sum[32] ? 32'hffffffff : fp_sum[31:0];
          state <= ST_DIVS;
        end
        ST_DIVS: state <= ST_DIV;
        ST_DIV: begin
          if (dv_done) begin
            k     <= (gate && !axis) ? 25'd0 : dv_q;
            state <= ST_UPD;
          end
        end
        ST_UPD: state <= ST_VAR;
        ST_VAR: begin
          if (axis) est_pitch <= tkf_pkg::sat32(f + 36'(t_upd));
          else      est_roll  <= tkf_pkg::sat32(f + 36'(t_upd));
          state <= ST_VST;
        end
        ST_VST: begin
          if (axis) begin
            var_pitch <= t_upd[31:0];
            state     <= ST_CMD1;
          end else begin
            var_roll <= t_upd[31:0];
            axis     <= 1'b1;
            state    <= ST_SQA;
          end
        end
        ST_CMD1: state <= ST_CMD2;
        ST_CMD2: begin
          fwd   <= tkf_pkg::sat16(40'(t_fwd));
          state <= ST_CMD3;
        end
        ST_CMD3: begin
          turn  <= tkf_pkg::sat16(40'(t_turn));
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            out_data <= {turn, fwd, acc13,
                         tkf_pkg::sat16(40'((33'(est_pitch) + 33'sd1024) >>> 11)),
                         tkf_pkg::sat16(40'((33'(est_roll) + 33'sd1024) >>> 11))};
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no second item is taken while one is at work
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("item accepted while busy");

  // gain is a fraction of one
  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> (k <= tkf_pkg::ONE_Q24))
    else $error("gain above one");

  // gated roll axis never corrects
  a_gate: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && !axis && gate) |-> (k == 25'd0))
    else $error("gated roll gain not zero");

  // a result appears only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_OUT))
    else $error("unexpected result");
`endif

endmodule
`default_nettype wire
